[hdl/dpa_pkg.sv]
// Package for the demand page allocator: transaction structs, request and
// status codes, table geometry and reset values.
// No dependencies.
package dpa_pkg;

    localparam int TABLE_ENTRIES    = 1024;
    localparam int NUM_TABLES_DEF   = 4;
    localparam int DIR_DEPTH        = 1024;
    localparam int SLOT_W           = 10;
    localparam int DIR_ENTRY_W      = 3;
    localparam int COUNT_W          = 20;
    localparam int PAGE_SHIFT       = 12;

    localparam logic [31:0] START_ADDR_RST = 32'h0200_0000;

    localparam logic [1:0] REQ_FAULT  = 2'd0;
    localparam logic [1:0] REQ_DIR_WR = 2'd1;
    localparam logic [1:0] REQ_PT_WR  = 2'd2;

    localparam logic [1:0] ST_PRESENT = 2'd0;
    localparam logic [1:0] ST_ALLOC   = 2'd1;
    localparam logic [1:0] ST_NOTABLE = 2'd2;
    localparam logic [1:0] ST_WRITTEN = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [31:0]       virtual_address;
        logic [SLOT_W-1:0] dir_slot;
        logic [1:0]        table_number;
        logic [SLOT_W-1:0] table_slot;
        logic              entry_present;
        logic [31:0]       entry_word;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] phys_address;
    } rsp_t;

    // directory memory port: one write and one read per cycle
    typedef struct packed {
        logic                   we;
        logic [SLOT_W-1:0]      waddr;
        logic [DIR_ENTRY_W-1:0] wdata;
        logic                   re;
        logic [SLOT_W-1:0]      raddr;
    } dir_port_t;

endpackage

[hdl/dpa_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module dpa_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/dpa_ctrl.sv]
// Walk sequencer: clearing pass, directory and page table lookups,
// frame allocation, write-back, directory and table write requests and the output register.
// Depends on dpa_pkg.
module dpa_ctrl #(
    parameter int NUM_TABLES = dpa_pkg::NUM_TABLES_DEF,
    parameter int PT_AW      = $clog2(NUM_TABLES * dpa_pkg::TABLE_ENTRIES)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [31-dpa_pkg::PAGE_SHIFT:0]  start_frame,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dpa_pkg::req_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dpa_pkg::rsp_t                    m_data,
    output dpa_pkg::dir_port_t               dir_port,
    input  logic [dpa_pkg::DIR_ENTRY_W-1:0]  dir_rdata,
    output logic                             pt_we,
    output logic [PT_AW-1:0]                 pt_waddr,
    output logic [31:0]                      pt_wdata,
    output logic                             pt_re,
    output logic [PT_AW-1:0]                 pt_raddr,
    input  logic [31:0]                      pt_rdata
);

    localparam int PT_DEPTH = NUM_TABLES * dpa_pkg::TABLE_ENTRIES;
    localparam int SW       = dpa_pkg::SLOT_W;
    localparam int FW       = 32 - dpa_pkg::PAGE_SHIFT;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIR   = 3'd2;
    localparam logic [2:0] S_PT    = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    function automatic logic [PT_AW-1:0] pt_addr(input logic [1:0] tnum,
                                                 input logic [SW-1:0] slot);
        logic [PT_AW+SW+1:0] wide;
        wide = (PT_AW+SW+2)'({tnum, slot});
        return wide[PT_AW-1:0];
    endfunction

    logic [2:0]              state_reg, state_next;
    logic [PT_AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [dpa_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [SW-1:0]           tslot_reg, tslot_next;
    logic [PT_AW-1:0]        idx_reg, idx_next;
    dpa_pkg::rsp_t           res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    dpa_pkg::rsp_t           out_data_reg, out_data_next;

    logic                    accept;
    logic                    out_free;
    logic                    fin_valid;
    dpa_pkg::rsp_t           fin_data;
    logic                    dir_ok;
    logic [1:0]              dtab;
    logic [FW-1:0]           new_frame;

    assign accept    = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign dtab      = dir_rdata[2:1];
    assign dir_ok    = dir_rdata[0] && (32'(dtab) < NUM_TABLES);
    assign new_frame = start_frame + FW'(count_reg);

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        count_next     = count_reg;
        tslot_next     = tslot_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        fin_valid      = 1'b0;
        fin_data       = '0;

        dir_port       = '0;
        pt_we          = 1'b0;
        pt_waddr       = idx_reg;
        pt_wdata       = '0;
        pt_re          = 1'b0;
        pt_raddr       = pt_addr(dtab, tslot_reg);

        case (state_reg)
            S_CLEAR: begin
                dir_port.we    = 1'b1;
                dir_port.waddr = clr_cnt_reg[SW-1:0];
                pt_we          = 1'b1;
                pt_waddr       = clr_cnt_reg;
                clr_cnt_next   = clr_cnt_reg + PT_AW'(1);
                if (clr_cnt_reg == PT_AW'(PT_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                dir_port.raddr = s_data.virtual_address[31:32-SW];
                if (accept) begin
                    case (s_data.req_type)
                        dpa_pkg::REQ_FAULT: begin
                            dir_port.re = 1'b1;
                            tslot_next  = s_data.virtual_address[31-SW:dpa_pkg::PAGE_SHIFT];
                            state_next  = S_DIR;
                        end
                        dpa_pkg::REQ_DIR_WR: begin
                            dir_port.we    = 1'b1;
                            dir_port.waddr = s_data.dir_slot;
                            dir_port.wdata = {s_data.table_number, s_data.entry_present};
                        end
                        dpa_pkg::REQ_PT_WR: begin
                            pt_we    = (32'(s_data.table_number) < NUM_TABLES);
                            pt_waddr = pt_addr(s_data.table_number, s_data.table_slot);
                            pt_wdata = s_data.entry_word;
                        end
                        default: begin
                        end
                    endcase
                    if (s_data.req_type != dpa_pkg::REQ_FAULT) begin
                        fin_valid       = 1'b1;
                        fin_data.status = dpa_pkg::ST_WRITTEN;
                    end
                end
            end
            S_DIR: begin
                if (dir_ok) begin
                    pt_re      = 1'b1;
                    idx_next   = pt_raddr;
                    state_next = S_PT;
                end else begin
                    fin_valid       = 1'b1;
                    fin_data.status = dpa_pkg::ST_NOTABLE;
                end
            end
            S_PT: begin
                fin_valid = 1'b1;
                if (pt_rdata[0]) begin
                    fin_data.status       = dpa_pkg::ST_PRESENT;
                    fin_data.phys_address = {pt_rdata[31:dpa_pkg::PAGE_SHIFT],
                                             dpa_pkg::PAGE_SHIFT'(0)};
                end else begin
                    // allocate: present and writable
                    pt_we                 = 1'b1;
                    pt_wdata              = {new_frame, dpa_pkg::PAGE_SHIFT'(3)};
                    count_next            = count_reg + dpa_pkg::COUNT_W'(1);
                    fin_data.status       = dpa_pkg::ST_ALLOC;
                    fin_data.phys_address = {new_frame, dpa_pkg::PAGE_SHIFT'(0)};
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // result goes straight to the output register when it is free
        if (fin_valid) begin
            if (out_free) begin
                state_next = S_IDLE;
            end else begin
                res_next   = fin_data;
                state_next = S_FIN;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fin_valid && out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = fin_data;
        end else if (state_reg == S_FIN && out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tslot_reg    <= tslot_next;
        idx_reg      <= idx_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[hdl/demand_page_allocator_core.sv]
// Page fault: accept with the directory read, then the dependent table read,
// then the write-back, with the result going to the output register. No new
// request is accepted until a fault is done; writes one per cycle while the
// output is not stalled. Reset: synchronous, active low; a clearing pass
// zeroes directory and page tables, no transaction accepted during it.
// Top level of the demand page allocator; depends on dpa_pkg, dpa_ram, dpa_ctrl.
module demand_page_allocator_core #(
    parameter int NUM_TABLES = dpa_pkg::NUM_TABLES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  dpa_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output dpa_pkg::rsp_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);

    localparam int PT_DEPTH = NUM_TABLES * dpa_pkg::TABLE_ENTRIES;
    localparam int PT_AW    = $clog2(PT_DEPTH);

    logic [31:0]                       start_reg;
    dpa_pkg::dir_port_t                dir_port;
    logic [dpa_pkg::DIR_ENTRY_W-1:0]   dir_rdata;
    logic                              pt_we;
    logic [PT_AW-1:0]                  pt_waddr;
    logic [31:0]                       pt_wdata;
    logic                              pt_re;
    logic [PT_AW-1:0]                  pt_raddr;
    logic [31:0]                       pt_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= dpa_pkg::START_ADDR_RST;
        end else if (cfg_valid) begin
            start_reg <= cfg_data;
        end
    end

    dpa_ram #(
        .W     (dpa_pkg::DIR_ENTRY_W),
        .DEPTH (dpa_pkg::DIR_DEPTH),
        .AW    (dpa_pkg::SLOT_W)
    ) u_dir_ram (
        .aclk  (aclk),
        .we    (dir_port.we),
        .waddr (dir_port.waddr),
        .wdata (dir_port.wdata),
        .re    (dir_port.re),
        .raddr (dir_port.raddr),
        .rdata (dir_rdata)
    );

    dpa_ram #(
        .W     (32),
        .DEPTH (PT_DEPTH),
        .AW    (PT_AW)
    ) u_pt_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    dpa_ctrl #(
        .NUM_TABLES (NUM_TABLES),
        .PT_AW      (PT_AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_frame (start_reg[31:dpa_pkg::PAGE_SHIFT]),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .dir_port    (dir_port),
        .dir_rdata   (dir_rdata),
        .pt_we       (pt_we),
        .pt_waddr    (pt_waddr),
        .pt_wdata    (pt_wdata),
        .pt_re       (pt_re),
        .pt_raddr    (pt_raddr),
        .pt_rdata    (pt_rdata)
    );

endmodule
